FILE: rtl/fp16_fused_multiply_add_truncating_defines.svh
// Assertion macros shared by the half-precision multiply-add block.
`ifndef FP16_FUSED_MULTIPLY_ADD_TRUNCATING_DEFINES_SVH
`define FP16_FUSED_MULTIPLY_ADD_TRUNCATING_DEFINES_SVH
// Asserts that an antecedent implies a consequent on the next clock edge.
`define FMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Asserts that a condition holds at every clock edge outside reset.
`define FMA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`endif

FILE: rtl/fma16_pkg.sv
// Package with the types and constants of the half-precision multiply-add.
package fma16_pkg;
    localparam int unsigned EXP_BIAS    = 15;
    localparam int unsigned ALIGN_LIMIT = 22;
    localparam logic [4:0]  EXP_MAX     = 5'h1F;
    localparam logic [9:0]  MANT_MAX    = 10'h3FF;

    // Count of leading zeros above bit 21 of a 23-bit sum, -1 when bit 22 is set.
    function automatic logic signed [5:0] lead_shift(input logic [22:0] v);
        logic signed [5:0] r;
        r = 6'sd0;
        for (int i = 0; i <= 22; i++)
        begin
            if (v[i])
            begin
                r = 6'(21 - i);
            end
        end
        return r;
    endfunction
endpackage

FILE: rtl/fp16_fused_multiply_add_truncating.sv
// Half-precision fused multiply-add, truncating: four-stage pipeline.
// done is the valid bit of the last stage and is high while the result word is on sum_out.
// One word is accepted a cycle; busy is held low, as no stage ever stalls.
// The stages are multiply, compare and align, add and leading-one count, pack.
// Reset clears the valid bits of every stage; the data registers are not reset.
`include "fp16_fused_multiply_add_truncating_defines.svh"
module fp16_fused_multiply_add_truncating
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] mult_a,
    input  logic [15:0] mult_b,
    input  logic [15:0] addend,
    output logic        done,
    output logic [15:0] sum_out
);
    logic        v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage one: significand product and product exponent, and the addend's significand and exponent.
    logic [21:0] p1_reg, p1_next;
    logic [5:0]  ep1_reg, ep1_next;
    logic [21:0] sc1_reg, sc1_next;
    logic [5:0]  ec1_reg, ec1_next;
    logic        sp1_reg, scs1_reg;
    logic [21:0] raw_prod;

    always_comb
    begin
        raw_prod = {11'd0, 1'b1, mult_a[9:0]} * {11'd0, 1'b1, mult_b[9:0]};
        if (mult_a[14:10] == 5'd0 || mult_b[14:10] == 5'd0)
        begin
            p1_next  = '0;
            ep1_next = '0;
        end
        else if (raw_prod[21])
        begin
            p1_next  = raw_prod;
            ep1_next = 6'({1'b0, mult_a[14:10]} + {1'b0, mult_b[14:10]} + 6'd1);
        end
        else
        begin
            p1_next  = {raw_prod[20:0], 1'b0};
            ep1_next = 6'({1'b0, mult_a[14:10]} + {1'b0, mult_b[14:10]});
        end
        sc1_next = (addend[14:10] == 5'd0) ? '0 : {1'b1, addend[9:0], 11'd0};
        ec1_next = 6'({1'b0, addend[14:10]} + 6'(fma16_pkg::EXP_BIAS));
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= p1_next;
        ep1_reg  <= ep1_next;
        sc1_reg  <= sc1_next;
        ec1_reg  <= ec1_next;
        sp1_reg  <= mult_a[15] ^ mult_b[15];
        scs1_reg <= addend[15];
    end

    // Stage two: magnitude compare, swap and alignment shift.
    logic        big;
    logic [5:0]  diff;
    logic [21:0] ml2_reg, ml2_next, ms2_reg, ms2_next, ms_pre;
    logic [5:0]  el2_reg, el2_next;
    logic        sgn2_reg, sgn2_next, sub2_reg;

    always_comb
    begin
        big = {ep1_reg, p1_reg} >= {ec1_reg, sc1_reg};
        sgn2_next = (sp1_reg == scs1_reg) ? sp1_reg : (big ? sp1_reg : scs1_reg);
        if (big)
        begin
            el2_next = ep1_reg;
            ml2_next = p1_reg;
            ms_pre   = sc1_reg;
            diff     = ep1_reg - ec1_reg;
        end
        else
        begin
            el2_next = ec1_reg;
            ml2_next = sc1_reg;
            ms_pre   = p1_reg;
            diff     = ec1_reg - ep1_reg;
        end
        ms2_next = (diff >= 6'(fma16_pkg::ALIGN_LIMIT)) ? '0 : (ms_pre >> diff);
    end

    always_ff @(posedge clk)
    begin
        ml2_reg  <= ml2_next;
        ms2_reg  <= ms2_next;
        el2_reg  <= el2_next;
        sgn2_reg <= sgn2_next;
        sub2_reg <= sp1_reg ^ scs1_reg;
    end

    // Stage three: add or subtract, then count to the leading one.
    logic [22:0]       sum3_reg, sum3_next;
    logic signed [5:0] sh3_reg;
    logic [5:0]        el3_reg;
    logic              sgn3_reg;

    always_comb
    begin
        if (sub2_reg)
        begin
            sum3_next = {1'b0, 22'(ml2_reg - ms2_reg)};
        end
        else
        begin
            sum3_next = {1'b0, ml2_reg} + {1'b0, ms2_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        sum3_reg <= sum3_next;
        sh3_reg  <= fma16_pkg::lead_shift(sum3_next);
        el3_reg  <= el2_reg;
        sgn3_reg <= sgn2_reg;
    end

    // Stage four: normalise, truncate and pack with saturation or flush.
    logic signed [7:0] expo;
    logic [21:0]       norm;
    logic [15:0]       sum_out_reg, sum_out_next;

    always_comb
    begin
        expo = $signed({2'b00, el3_reg}) - 8'(sh3_reg) - 8'sd15;
        if (sh3_reg < 0)
        begin
            norm = sum3_reg[22:1];
        end
        else
        begin
            norm = 22'(sum3_reg << sh3_reg);
        end
        if (sum3_reg == '0 || expo <= 0)
        begin
            sum_out_next = {sgn3_reg, 15'd0};
        end
        else if (expo >= 32)
        begin
            sum_out_next = {sgn3_reg, fma16_pkg::EXP_MAX, fma16_pkg::MANT_MAX};
        end
        else
        begin
            sum_out_next = {sgn3_reg, expo[4:0], norm[20:11]};
        end
    end

    always_ff @(posedge clk)
    begin
        sum_out_reg <= sum_out_next;
    end

    // Valid bits travel with each word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign busy    = 1'b0;
    assign done    = v4_reg;
    assign sum_out = sum_out_reg;

    // Checks on the pipeline's control and data.
    `FMA_ASSERT_NEXT(a_valid_moves, clk, rst_n, v3_reg, done, "valid bit lost in the pipeline")
    `FMA_ASSERT_NEXT(a_start_flows, clk, rst_n, start, v1_reg, "accepted word not captured")
    `FMA_ASSERT_ALWAYS(a_flush_zero, clk, rst_n,
        !(done && sum_out[14:10] == 5'd0) || sum_out[9:0] == 10'd0, "flushed word not zero")
endmodule
